>>> src/rhm_pkg.sv
// Package with shared types, codes and character constants of the master name extractor.
package rhm_pkg;

    localparam int QueueDepth = 4;
    localparam logic [4:0] HeaderLast = 5'd23;
    localparam logic [31:0] SubhdrLen = 32'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT_HDR = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_OVERRUN   = 3'd4;

    localparam logic KIND_NAME   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_M   = 8'h4D;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_SUBHDR  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_TAIL    = 3'd3,
        PH_DONE    = 3'd4,
        PH_BAD     = 3'd5
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] name_byte;
        logic       name_end;
        logic [2:0] status;
        logic       run_last;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] magic_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0: c = 8'h54;
            2'd1: c = 8'h45;
            2'd2: c = 8'h53;
            2'd3: c = 8'h34;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] tag_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0: c = 8'h4D;
            2'd1: c = 8'h41;
            2'd2: c = 8'h53;
            2'd3: c = 8'h54;
        endcase
        return c;
    endfunction

endpackage

>>> src/rhm_front.sv
// Front end: accepts file bytes, walks header and subrecords, and forms result groups.
module rhm_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             file_byte,
    input  logic                   end_of_file,
    input  rhm_pkg::queue_status_t q_status,
    output logic                   wr_en,
    output rhm_pkg::item_t         wr_item
);
    import rhm_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [4:0]  header_count_reg, header_count_next;
    logic        magic_good_reg, magic_good_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [2:0]  sub_count_reg, sub_count_next;
    logic        tag_matches_reg, tag_matches_next;
    logic [15:0] payload_left_reg, payload_left_next;
    logic        name_open_reg, name_open_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        held_valid_reg, held_valid_next;
    logic [2:0]  walk_status_reg, walk_status_next;

    logic        accept;
    logic [31:0] rem_dec;
    logic [15:0] size_full;
    logic [1:0]  n;
    result_t     res [2];
    logic [2:0]  st;

    assign full    = q_status.full;
    assign accept  = push && !q_status.full;
    assign rem_dec = remaining_reg - 32'd1;
    assign size_full = {file_byte, payload_left_reg[7:0]};

    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        magic_good_next   = magic_good_reg;
        remaining_next    = remaining_reg;
        sub_count_next    = sub_count_reg;
        tag_matches_next  = tag_matches_reg;
        payload_left_next = payload_left_reg;
        name_open_next    = name_open_reg;
        held_byte_next    = held_byte_reg;
        held_valid_next   = held_valid_reg;
        walk_status_next  = walk_status_reg;
        n      = 2'd0;
        res[0] = '0;
        res[1] = '0;
        st     = ST_OK;

        if (accept)
        begin
            if (held_valid_reg && !name_open_reg)
            begin
                res[0] = '{kind: KIND_NAME, name_byte: held_byte_reg, name_end: 1'b1,
                           status: ST_OK, run_last: 1'b0};
                n = 2'd1;
                held_valid_next = 1'b0;
            end

            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (header_count_reg < 5'd4)
                    begin
                        if (file_byte != magic_char(header_count_reg[1:0]))
                            magic_good_next = 1'b0;
                    end
                    else if (header_count_reg < 5'd8)
                    begin
                        remaining_next[{header_count_reg[1:0], 3'b000} +: 8] = file_byte;
                    end
                    if (header_count_reg == HeaderLast)
                    begin
                        if (!magic_good_next)
                            phase_next = PH_BAD;
                        else if (remaining_next == 32'd0)
                            phase_next = PH_DONE;
                        else
                            phase_next = PH_SUBHDR;
                    end
                    else
                    begin
                        header_count_next = header_count_reg + 5'd1;
                    end
                end
                PH_SUBHDR, PH_PAYLOAD, PH_TAIL:
                begin
                    remaining_next = rem_dec;
                    if (phase_reg == PH_SUBHDR)
                    begin
                        if (sub_count_reg == 3'd0)
                        begin
                            if (remaining_reg < SubhdrLen)
                                phase_next = PH_TAIL;
                            else
                            begin
                                tag_matches_next = (file_byte == CHAR_M);
                                sub_count_next = 3'd1;
                            end
                        end
                        else if (sub_count_reg < 3'd4)
                        begin
                            if (file_byte != tag_char(sub_count_reg[1:0]))
                                tag_matches_next = 1'b0;
                            sub_count_next = sub_count_reg + 3'd1;
                        end
                        else if (sub_count_reg == 3'd4)
                        begin
                            payload_left_next = {8'h00, file_byte};
                            sub_count_next = 3'd5;
                        end
                        else
                        begin
                            payload_left_next = size_full;
                            sub_count_next = 3'd0;
                            if ({16'h0000, size_full} > rem_dec)
                            begin
                                walk_status_next = ST_OVERRUN;
                                phase_next = PH_TAIL;
                            end
                            else if (size_full != 16'd0)
                            begin
                                phase_next = PH_PAYLOAD;
                                name_open_next = tag_matches_reg;
                                held_valid_next = 1'b0;
                            end
                        end
                    end
                    else if (phase_reg == PH_PAYLOAD)
                    begin
                        payload_left_next = payload_left_reg - 16'd1;
                        if (name_open_reg)
                        begin
                            if (held_valid_next)
                            begin
                                res[n[0]] = '{kind: KIND_NAME, name_byte: held_byte_reg,
                                              name_end: (file_byte == CHAR_NUL),
                                              status: ST_OK, run_last: 1'b0};
                                n = n + 2'd1;
                            end
                            if (file_byte == CHAR_NUL)
                            begin
                                held_valid_next = 1'b0;
                                name_open_next = 1'b0;
                            end
                            else
                            begin
                                held_byte_next = file_byte;
                                held_valid_next = 1'b1;
                            end
                        end
                        if (payload_left_next == 16'd0)
                        begin
                            phase_next = PH_SUBHDR;
                            name_open_next = 1'b0;
                        end
                    end
                    if (rem_dec == 32'd0)
                        phase_next = PH_DONE;
                end
                default:
                begin
                end
            endcase

            if (end_of_file)
            begin
                priority case (phase_next)
                    PH_HEADER:                      st = ST_SHORT_HDR;
                    PH_BAD:                         st = ST_BAD_MAGIC;
                    PH_SUBHDR, PH_PAYLOAD, PH_TAIL: st = ST_TRUNCATED;
                    default:                        st = walk_status_next;
                endcase
                res[n[0]] = '{kind: KIND_STATUS,
                              name_byte: (held_valid_next && !name_open_next) ?
                                         held_byte_next : 8'h00,
                              name_end: held_valid_next && !name_open_next,
                              status: st, run_last: 1'b0};
                n = n + 2'd1;

                phase_next        = PH_HEADER;
                header_count_next = 5'd0;
                magic_good_next   = 1'b1;
                remaining_next    = 32'd0;
                sub_count_next    = 3'd0;
                tag_matches_next  = 1'b1;
                payload_left_next = 16'd0;
                name_open_next    = 1'b0;
                held_byte_next    = 8'h00;
                held_valid_next   = 1'b0;
                walk_status_next  = ST_OK;
            end

            if (n == 2'd1)
                res[0].run_last = 1'b1;
            else if (n == 2'd2)
                res[1].run_last = 1'b1;
        end
    end

    assign wr_en          = accept && (n != 2'd0);
    assign wr_item.two    = (n == 2'd2);
    assign wr_item.first  = res[0];
    assign wr_item.second = res[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            header_count_reg <= 5'd0;
            magic_good_reg   <= 1'b1;
            remaining_reg    <= 32'd0;
            sub_count_reg    <= 3'd0;
            tag_matches_reg  <= 1'b1;
            payload_left_reg <= 16'd0;
            name_open_reg    <= 1'b0;
            held_byte_reg    <= 8'h00;
            held_valid_reg   <= 1'b0;
            walk_status_reg  <= ST_OK;
        end
        else
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            magic_good_reg   <= magic_good_next;
            remaining_reg    <= remaining_next;
            sub_count_reg    <= sub_count_next;
            tag_matches_reg  <= tag_matches_next;
            payload_left_reg <= payload_left_next;
            name_open_reg    <= name_open_next;
            held_byte_reg    <= held_byte_next;
            held_valid_reg   <= held_valid_next;
            walk_status_reg  <= walk_status_next;
        end
    end

endmodule

>>> src/rhm_queue.sv
// Short queue of result groups between the front end and the back end.
module rhm_queue #(
    parameter int Depth = rhm_pkg::QueueDepth
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  rhm_pkg::item_t         wr_item,
    input  logic                   rd_en,
    output rhm_pkg::item_t         rd_item,
    output rhm_pkg::queue_status_t q_status
);
    import rhm_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [CntW-1:0] CountMax = CntW'(Depth);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [PtrW-1:0] PtrOne = PtrW'(1);
    localparam logic [CntW-1:0] CountOne = CntW'(1);

    item_t           mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_wr, do_rd;

    assign q_status.full  = (count_reg == CountMax);
    assign q_status.empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_status.full;
    assign do_rd   = rd_en && !q_status.empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + PtrOne;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + PtrOne;
        if (do_wr && !do_rd)
            count_next = count_reg + CountOne;
        else if (do_rd && !do_wr)
            count_next = count_reg - CountOne;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/rhm_back.sv
// Back end: splits result groups into single results and holds them in the output register.
module rhm_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rhm_pkg::item_t         rd_item,
    input  rhm_pkg::queue_status_t q_status,
    output logic                   rd_en,
    input  logic                   pop,
    output logic                   empty,
    output rhm_pkg::result_t       out_result
);
    import rhm_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    second_reg, second_next;
    logic    load;

    assign load  = (!out_valid_reg || pop) && !q_status.empty;
    assign empty = !out_valid_reg;
    assign out_result = out_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        second_next    = second_reg;
        rd_en          = 1'b0;
        if (out_valid_reg && pop)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_next = second_reg ? rd_item.second : rd_item.first;
            if (second_reg || !rd_item.two)
            begin
                rd_en = 1'b1;
                second_next = 1'b0;
            end
            else
            begin
                second_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

endmodule

>>> src/record_header_master_name_extractor_top.sv
// Top level of the master name extractor: front end, group queue and back end.
// A request puts any result group it yields in the queue, which feeds the output register.
// One file byte per cycle is accepted while the queue is not full; results are drained at
// one per cycle while pop is high and results are waiting. A byte that yields two results
// hands them out in turn through the single output register. Reset is asynchronous, active
// low: the parser returns to the header phase, queue and output register empty.
module record_header_master_name_extractor_top #(
    parameter int QueueDepth = rhm_pkg::QueueDepth
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] file_byte,
    input  logic       end_of_file,
    output logic       empty,
    input  logic       pop,
    output logic       kind,
    output logic [7:0] name_byte,
    output logic       name_end,
    output logic [2:0] status,
    output logic       run_last
);
    import rhm_pkg::*;

    queue_status_t q_status;
    logic          wr_en;
    item_t         wr_item;
    logic          rd_en;
    item_t         rd_item;
    result_t       out_result;

    rhm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .file_byte   (file_byte),
        .end_of_file (end_of_file),
        .q_status    (q_status),
        .wr_en       (wr_en),
        .wr_item     (wr_item)
    );

    rhm_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_item  (wr_item),
        .rd_en    (rd_en),
        .rd_item  (rd_item),
        .q_status (q_status)
    );

    rhm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_item    (rd_item),
        .q_status   (q_status),
        .rd_en      (rd_en),
        .pop        (pop),
        .empty      (empty),
        .out_result (out_result)
    );

    assign kind      = out_result.kind;
    assign name_byte = out_result.name_byte;
    assign name_end  = out_result.name_end;
    assign status    = out_result.status;
    assign run_last  = out_result.run_last;

endmodule
